@@ src/tbp_pkg.sv @@
// ----------------------------------------------------------------------------
// tbp_pkg
// shared types and constants of the tournament branch predictor
// ----------------------------------------------------------------------------
`default_nettype none

package tbp_pkg;

  // table geometry; the chooser row lives next to the bimodal counter,
  // so both use the same index width
  localparam int BIMODAL_INDEX_BITS = 12;
  localparam int GSHARE_INDEX_BITS  = 13;
  localparam int BC_DEPTH           = 1 << BIMODAL_INDEX_BITS;
  localparam int GS_DEPTH           = 1 << GSHARE_INDEX_BITS;
  localparam int MAX_INDEX_BITS     = (GSHARE_INDEX_BITS > BIMODAL_INDEX_BITS) ?
                                      GSHARE_INDEX_BITS : BIMODAL_INDEX_BITS;
  localparam int CLEAR_BITS         = MAX_INDEX_BITS + 1;

  localparam int PC_BITS       = 32;
  localparam int CTR_BITS      = 2;
  localparam logic [CTR_BITS-1:0] COUNTER_MAX = 2'd3;
  localparam int HIST_BITS     = 16;
  localparam int HIST_LEN_BITS = 5;

  // result queue behind the update stage
  localparam int OUT_DEPTH    = 3;
  localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

  // configuration port
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [1:0] {
    MODE_BIMODAL    = 2'd0,
    MODE_GSHARE     = 2'd1,
    MODE_TOURNAMENT = 2'd2
  } mode_e;

  typedef enum logic {
    REG_PREDICT_MODE = 1'b0,
    REG_HIST_LEN     = 1'b1
  } reg_e;

  localparam logic [1:0]               MODE_RESET     = MODE_TOURNAMENT;
  localparam logic [HIST_LEN_BITS-1:0] HIST_LEN_RESET = 5'd12;

  typedef struct packed {
    logic [PC_BITS-1:0] branch_pc;
    logic               actual_taken;
  } tbp_in_t;

  typedef struct packed {
    logic predicted_taken;
    logic chose_gshare;
  } tbp_out_t;

endpackage

`default_nettype wire

@@ src/tournament_branch_predictor.sv @@
// ----------------------------------------------------------------------------
// tournament_branch_predictor
// bimodal + gshare predictor with a chooser table, trained on every branch
// ----------------------------------------------------------------------------
// pipeline: the accept stage issues the table reads, then the update stage
//   predicts, trains, writes back and pushes the result into the result queue
// throughput: one item per cycle while the input is not stalled; each table
//   memory can do one read and one write a cycle, and the update stage forwards its own last write
// reset: a clearing pass zeroes the tables, one row a cycle;
//   input stays stalled meanwhile, configuration writes are taken as ever
`default_nettype none

module tournament_branch_predictor (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // branch items
  input  wire logic                                in_valid_i,
  output      logic                                in_stall_o,
  input  wire tbp_pkg::tbp_in_t                    in_data_i,
  // prediction items
  output      logic                                out_valid_o,
  input  wire logic                                out_stall_i,
  output      tbp_pkg::tbp_out_t                   out_data_o,
  // configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [tbp_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  wire logic [tbp_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output      logic [tbp_pkg::CFG_DATA_BITS-1:0]   prdata,
  output      logic                                pready
);

  localparam int BI = tbp_pkg::BIMODAL_INDEX_BITS;
  localparam int GI = tbp_pkg::GSHARE_INDEX_BITS;
  localparam int CB = tbp_pkg::CTR_BITS;

  // 2-bit saturating counter step
  function automatic logic [CB-1:0] train_ctr(input logic [CB-1:0] c, input logic up);
    if (up) begin
      return (c == tbp_pkg::COUNTER_MAX) ? c : c + 1'b1;
    end
    return (c == '0) ? c : c - 1'b1;
  endfunction

  function automatic logic [tbp_pkg::OUT_PTR_BITS-1:0] ptr_inc(
      input logic [tbp_pkg::OUT_PTR_BITS-1:0] p);
    if (p == tbp_pkg::OUT_PTR_BITS'(tbp_pkg::OUT_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [1:0]                        mode_q, mode_d;
  logic [tbp_pkg::HIST_LEN_BITS-1:0] hist_len_q, hist_len_d;
  logic                              cfg_we;
  tbp_pkg::reg_e                     cfg_reg;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_reg = tbp_pkg::reg_e'(paddr[tbp_pkg::CFG_ADDR_BITS-1]);

  always_comb begin
    mode_d     = mode_q;
    hist_len_d = hist_len_q;
    if (cfg_we) begin
      unique case (cfg_reg)
        tbp_pkg::REG_PREDICT_MODE: mode_d     = pwdata[1:0];
        tbp_pkg::REG_HIST_LEN:     hist_len_d = pwdata[tbp_pkg::HIST_LEN_BITS-1:0];
        default:                   mode_d     = mode_q;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      tbp_pkg::REG_PREDICT_MODE: prdata = tbp_pkg::CFG_DATA_BITS'(mode_q);
      tbp_pkg::REG_HIST_LEN:     prdata = tbp_pkg::CFG_DATA_BITS'(hist_len_q);
      default:                   prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // clearing pass after reset
  // --------------------------------------------------------------------------
  logic [tbp_pkg::CLEAR_BITS-1:0] clr_cnt_q, clr_cnt_d;
  logic                           clearing;

  // top bit set once every row of the deepest table has been written
  assign clearing  = ~clr_cnt_q[tbp_pkg::CLEAR_BITS-1];
  assign clr_cnt_d = clearing ? clr_cnt_q + 1'b1 : clr_cnt_q;

  // --------------------------------------------------------------------------
  // accept stage: form indices, update history, issue reads
  // --------------------------------------------------------------------------
  logic                              accept_in;
  logic [tbp_pkg::HIST_BITS-1:0]     hist_q, hist_d, hist_mask;
  logic [BI-1:0]                     bc_idx;
  logic [GI-1:0]                     gs_idx;

  assign accept_in = in_valid_i & ~in_stall_o;
  assign bc_idx    = in_data_i.branch_pc[BI-1:0];
  // history before this branch is shifted in
  assign gs_idx    = in_data_i.branch_pc[GI-1:0] ^ GI'(hist_q);

  // lengths above the register width simply keep every bit
  always_comb begin
    for (int i = 0; i < tbp_pkg::HIST_BITS; i++) begin
      hist_mask[i] = (tbp_pkg::HIST_LEN_BITS'(i) < hist_len_q);
    end
  end

  assign hist_d = accept_in ?
                  ({hist_q[tbp_pkg::HIST_BITS-2:0], in_data_i.actual_taken} & hist_mask) :
                  hist_q;

  // --------------------------------------------------------------------------
  // table memories: bimodal and chooser share a row, gshare on its own
  // --------------------------------------------------------------------------
  logic [2*CB-1:0] bc_mem [tbp_pkg::BC_DEPTH];
  logic [CB-1:0]   gs_mem [tbp_pkg::GS_DEPTH];
  logic [2*CB-1:0] bc_rdata_q, bc_wdata;
  logic [CB-1:0]   gs_rdata_q, gs_wdata;
  logic [BI-1:0]   bc_waddr;
  logic [GI-1:0]   gs_waddr;
  logic            bc_we, gs_we;

  always_ff @(posedge clk_i) begin
    bc_rdata_q <= bc_mem[bc_idx];
    if (bc_we) begin
      bc_mem[bc_waddr] <= bc_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    gs_rdata_q <= gs_mem[gs_idx];
    if (gs_we) begin
      gs_mem[gs_waddr] <= gs_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // update stage: predict, train, write back
  // --------------------------------------------------------------------------
  logic            s1_valid_q;
  logic [BI-1:0]   s1_bc_idx_q;
  logic [GI-1:0]   s1_gs_idx_q;
  logic            s1_taken_q;

  // last write of the update stage; a read issued at the same edge missed it
  logic            fwd_bc_valid_q, fwd_gs_valid_q;
  logic [BI-1:0]   fwd_bc_idx_q;
  logic [GI-1:0]   fwd_gs_idx_q;
  logic [2*CB-1:0] fwd_bc_data_q;
  logic [CB-1:0]   fwd_gs_data_q;

  logic [2*CB-1:0] bc_cur;
  logic [CB-1:0]   gs_cur, bim_ctr, cho_ctr, bim_new, gs_new, cho_new;
  logic            bpred, gpred, use_g, pred;
  tbp_pkg::tbp_out_t s1_result;

  assign bc_cur = (fwd_bc_valid_q && fwd_bc_idx_q == s1_bc_idx_q) ? fwd_bc_data_q : bc_rdata_q;
  assign gs_cur = (fwd_gs_valid_q && fwd_gs_idx_q == s1_gs_idx_q) ? fwd_gs_data_q : gs_rdata_q;

  assign bim_ctr = bc_cur[CB-1:0];
  assign cho_ctr = bc_cur[2*CB-1:CB];
  assign bpred   = bim_ctr[CB-1];
  assign gpred   = gs_cur[CB-1];
  assign use_g   = cho_ctr[CB-1];

  always_comb begin
    case (tbp_pkg::mode_e'(mode_q))
      tbp_pkg::MODE_BIMODAL: pred = bpred;
      tbp_pkg::MODE_GSHARE:  pred = gpred;
      default:               pred = use_g ? gpred : bpred;  // unused code acts as tournament
    endcase
  end

  assign bim_new = train_ctr(bim_ctr, s1_taken_q);
  assign gs_new  = train_ctr(gs_cur, s1_taken_q);
  // chooser only moves when the two predictors disagree
  assign cho_new = (bpred != gpred) ? train_ctr(cho_ctr, gpred == s1_taken_q) : cho_ctr;

  assign s1_result.predicted_taken = pred;
  assign s1_result.chose_gshare    = use_g;

  // write port: clearing pass owns it until done, no item is in flight then
  always_comb begin
    if (clearing) begin
      bc_we    = (clr_cnt_q < tbp_pkg::CLEAR_BITS'(tbp_pkg::BC_DEPTH));
      bc_waddr = clr_cnt_q[BI-1:0];
      bc_wdata = '0;
      gs_we    = (clr_cnt_q < tbp_pkg::CLEAR_BITS'(tbp_pkg::GS_DEPTH));
      gs_waddr = clr_cnt_q[GI-1:0];
      gs_wdata = '0;
    end else begin
      bc_we    = s1_valid_q;
      bc_waddr = s1_bc_idx_q;
      bc_wdata = {cho_new, bim_new};
      gs_we    = s1_valid_q;
      gs_waddr = s1_gs_idx_q;
      gs_wdata = gs_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      s1_bc_idx_q <= bc_idx;
      s1_gs_idx_q <= gs_idx;
      s1_taken_q  <= in_data_i.actual_taken;
    end
    if (s1_valid_q) begin
      fwd_bc_idx_q  <= s1_bc_idx_q;
      fwd_bc_data_q <= {cho_new, bim_new};
      fwd_gs_idx_q  <= s1_gs_idx_q;
      fwd_gs_data_q <= gs_new;
    end
  end

  // --------------------------------------------------------------------------
  // result queue: keeps input flowing while the consumer stalls
  // --------------------------------------------------------------------------
  tbp_pkg::tbp_out_t                 fifo_q [tbp_pkg::OUT_DEPTH];
  logic [tbp_pkg::OUT_PTR_BITS-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [tbp_pkg::OUT_CNT_BITS-1:0]  cnt_q, cnt_d;
  logic [tbp_pkg::OUT_CNT_BITS:0]    occupancy;
  logic                              push, pop;

  assign push = s1_valid_q;
  assign pop  = out_valid_o & ~out_stall_i;

  assign wr_ptr_d = push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
  assign rd_ptr_d = pop  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
  assign cnt_d    = cnt_q + tbp_pkg::OUT_CNT_BITS'(push) - tbp_pkg::OUT_CNT_BITS'(pop);

  // items queued plus the one in the update stage must leave room for one more
  assign occupancy  = (tbp_pkg::OUT_CNT_BITS + 1)'(cnt_q) +
                      (tbp_pkg::OUT_CNT_BITS + 1)'(s1_valid_q);
  assign in_stall_o = clearing |
                      (occupancy >= (tbp_pkg::OUT_CNT_BITS + 1)'(tbp_pkg::OUT_DEPTH));

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= s1_result;
    end
  end

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= tbp_pkg::MODE_RESET;
      hist_len_q     <= tbp_pkg::HIST_LEN_RESET;
      hist_q         <= '0;
      clr_cnt_q      <= '0;
      s1_valid_q     <= 1'b0;
      fwd_bc_valid_q <= 1'b0;
      fwd_gs_valid_q <= 1'b0;
      wr_ptr_q       <= '0;
      rd_ptr_q       <= '0;
      cnt_q          <= '0;
    end else begin
      mode_q         <= mode_d;
      hist_len_q     <= hist_len_d;
      hist_q         <= hist_d;
      clr_cnt_q      <= clr_cnt_d;
      s1_valid_q     <= accept_in;
      fwd_bc_valid_q <= s1_valid_q;
      fwd_gs_valid_q <= s1_valid_q;
      wr_ptr_q       <= wr_ptr_d;
      rd_ptr_q       <= rd_ptr_d;
      cnt_q          <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ src/tbp_checker.sv @@
// ----------------------------------------------------------------------------
// tbp_checker
// port-level checks of the tournament branch predictor
// ----------------------------------------------------------------------------
`default_nettype none

module tbp_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_stall_o,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire tbp_pkg::tbp_out_t                 out_data_o,
  input wire logic                              pready
);

  logic in_acc;
  assign in_acc = in_valid_i & ~in_stall_o;

  // tables are being cleared right after reset, so no item gets in
  a_stall_after_reset: assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> in_stall_o)
    else $error("input not stalled after reset");

  // an output item appearing on an idle output was accepted at the input and passed the update stage
  a_out_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> $past(in_acc, 2))
    else $error("output item without matching input item");

  // a stalled output item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output item changed");

  // configuration never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind tournament_branch_predictor tbp_checker u_tbp_checker (.*);

`default_nettype wire
